// ===== hw/rtl/tlb_lookup_fifo_replace_core_macros.svh =====
// ----------------------------------------------------------------------------
// TLB lookup core assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef TLB_LOOKUP_FIFO_REPLACE_CORE_MACROS_SVH
`define TLB_LOOKUP_FIFO_REPLACE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TLBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TLBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TLBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tlbf_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB lookup package
// Field widths, default parameters and the beat types passed along the chain.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int TLB_DEPTH_DEF  = 32;
  localparam int PAGE_BYTES_DEF = 32;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int PID_W   = 16;
  localparam int LADDR_W = 32;
  localparam int PADDR_W = 32;
  localparam int PAGE_W  = 27;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
  } query_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
  } slot_t;

endpackage

// ===== hw/rtl/tlbf_split.sv =====
// ----------------------------------------------------------------------------
// TLB address split
// Splits a logical address into page and offset through a reciprocal
// multiply, a back-multiply and one correction step.
// ----------------------------------------------------------------------------
module tlbf_split #(
  parameter int ADDR_BITS  = tlbf_pkg::ADDR_BITS_DEF,
  parameter int PAGE_BYTES = tlbf_pkg::PAGE_BYTES_DEF,
  localparam int OFS_W     = $clog2(PAGE_BYTES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [tlbf_pkg::PID_W-1:0]   in_pid,
  input  logic [tlbf_pkg::LADDR_W-1:0] in_addr,
  output logic                         out_valid,
  output logic [tlbf_pkg::PID_W-1:0]   out_pid,
  output logic [tlbf_pkg::PAGE_W-1:0]  out_page,
  output logic [OFS_W-1:0]             out_offset
);
  import tlbf_pkg::*;

  localparam logic [LADDR_W-1:0] AMASK = (ADDR_BITS >= LADDR_W) ? {LADDR_W{1'b1}} :
                                         LADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] RECIP64 = (64'd1 << LADDR_W) / 64'(PAGE_BYTES);
  localparam logic [LADDR_W-1:0] RECIP = RECIP64[LADDR_W-1:0];
  localparam logic [16:0] PB = 17'(PAGE_BYTES);
  localparam logic [LADDR_W-1:0] PB32 = LADDR_W'(PAGE_BYTES);

  logic v0_r, v1_r, v2_r, v3_r;
  logic [LADDR_W-1:0] a0_r, a1_r, a2_r;
  logic [PID_W-1:0]   pid0_r, pid1_r, pid2_r, pid3_r;
  logic [LADDR_W-1:0] prod_hi_r, qest_r, qp_r;
  logic [PAGE_W-1:0]  page3_r;
  logic [OFS_W-1:0]   ofs3_r;

  logic [2*LADDR_W-1:0] prod;
  logic [LADDR_W+16:0]  qpw;
  logic [LADDR_W-1:0]   rem, rem_c, q_c;
  logic                 ge;

  assign prod  = a0_r * RECIP;
  assign qpw   = prod_hi_r * PB;
  assign rem   = a2_r - qp_r;
  assign ge    = (rem >= PB32);
  assign rem_c = ge ? (rem - PB32) : rem;
  assign q_c   = ge ? (qest_r + 1'b1) : qest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a0_r      <= in_addr & AMASK;
    pid0_r    <= in_pid;
    a1_r      <= a0_r;
    pid1_r    <= pid0_r;
    prod_hi_r <= prod[2*LADDR_W-1:LADDR_W];
    a2_r      <= a1_r;
    pid2_r    <= pid1_r;
    qest_r    <= prod_hi_r;
    qp_r      <= qpw[LADDR_W-1:0];
    pid3_r    <= pid2_r;
    page3_r   <= q_c[PAGE_W-1:0];
    ofs3_r    <= rem_c[OFS_W-1:0];
  end

  assign out_valid  = v3_r;
  assign out_pid    = pid3_r;
  assign out_page   = page3_r;
  assign out_offset = ofs3_r;

endmodule

// ===== hw/rtl/tlbf_cell.sv =====
// ----------------------------------------------------------------------------
// TLB cell
// One TLB slot: compares the passing query against its entry, marks a hit
// with its frame and hands the query on to the next cell.
// ----------------------------------------------------------------------------
module tlbf_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            active,
  input  logic            wr_en,
  input  tlbf_pkg::slot_t wr_data,
  input  tlbf_pkg::query_t q_in,
  output tlbf_pkg::query_t q_out
);
  import tlbf_pkg::*;

  logic   valid_r;
  slot_t  slot_r;
  query_t q_r, q_nxt;
  logic   match;

  assign match = q_in.valid && !q_in.hit && active && valid_r &&
                 (slot_r.pid == q_in.pid) && (slot_r.page == q_in.page);

  always_comb begin
    q_nxt = q_in;
    if (match) begin
      q_nxt.hit   = 1'b1;
      q_nxt.frame = slot_r.frame;
    end
  end

  always_ff @(posedge clk) begin
    q_r.hit   <= q_nxt.hit;
    q_r.pid   <= q_nxt.pid;
    q_r.page  <= q_nxt.page;
    q_r.frame <= q_nxt.frame;
    if (wr_en) begin
      slot_r <= wr_data;
    end
    if (!rst_n) begin
      valid_r   <= 1'b0;
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
      if (wr_en) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign q_out = q_r;

endmodule

// ===== hw/rtl/tlb_lookup_fifo_replace_core.sv =====
// ----------------------------------------------------------------------------
// TLB lookup core with FIFO replacement
// Fully associative TLB held as a row of slot cells.
// Input beat: process id and logical address. Output beat: physical address,
// page number and a hit flag. cfg_wr_en writes the count of slots in use.
// A lookup passes 4 register stages of address split (the first at the
// accepting edge), walks the cell row one cell a cycle, then takes 2
// stages to form the physical address. One lookup is in flight at a time.
// A miss inserts its entry into the next free slot, then over the oldest.
// in_tready rises again as the result enters the output register, so the
// next beat is taken while that result waits. A stalled receiver holds the
// finished result in a second register and keeps in_tready low.
// Reset empties all slots, the fill count and the FIFO pointer, and sets
// the slot count to 32.
// ----------------------------------------------------------------------------
`include "tlb_lookup_fifo_replace_core_macros.svh"

module tlb_lookup_fifo_replace_core #(
  parameter int TLB_DEPTH  = tlbf_pkg::TLB_DEPTH_DEF,
  parameter int PAGE_BYTES = tlbf_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_BITS  = tlbf_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [15:0] process_id, [47:16] logical_address
  input  logic [47:0]                in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] physical_address, [58:32] page_number, [63:59] zero
  output logic [63:0]                out_tdata,
  // [0] tlb_hit
  output logic                       out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [tlbf_pkg::CFG_W-1:0] cfg_wr_data
);
  import tlbf_pkg::*;

  localparam int NW    = $clog2(TLB_DEPTH + 1);
  localparam int PW    = $clog2(TLB_DEPTH);
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int OFS_W = $clog2(PAGE_BYTES);
  localparam logic [16:0] PB = 17'(PAGE_BYTES);

  logic [CFG_W-1:0] cfg_r;
  logic             busy_r;
  logic [NW-1:0]    fill_r, fill_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [NW-1:0]    n_act;
  logic [CW-1:0]    cfg_ext;

  logic             sp_valid;
  logic [PID_W-1:0] sp_pid;
  logic [PAGE_W-1:0] sp_page;
  logic [OFS_W-1:0] sp_ofs;
  logic [OFS_W-1:0] ofs_r;

  query_t chain [TLB_DEPTH+1];
  logic [TLB_DEPTH-1:0] active;
  logic [TLB_DEPTH-1:0] wr_en;
  slot_t  wr_data;
  query_t exit_q;
  logic   ins_en;
  logic [PW-1:0] ins_slot, old_slot;

  logic [PAGE_W+16:0]  fprod;
  logic                fin_valid_r;
  logic [PADDR_W-1:0]  fprod_r;
  logic                fin_hit_r;
  logic [PAGE_W-1:0]   fin_page_r;
  logic                load_out;
  logic [PADDR_W-1:0]  phys;

  logic                out_valid_r;
  logic [63:0]         out_data_r;
  logic                out_hit_r;

  assign in_tready = !busy_r;

  // slot count in use, clamped to 1 .. TLB_DEPTH
  always_comb begin
    cfg_ext = CW'(cfg_r);
    if (cfg_ext == '0) begin
      n_act = NW'(1);
    end else if (cfg_ext > CW'(TLB_DEPTH)) begin
      n_act = NW'(TLB_DEPTH);
    end else begin
      n_act = cfg_ext[NW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      active[i] = (NW'(i) < n_act);
      wr_en[i]  = ins_en && (ins_slot == PW'(i));
    end
  end

  tlbf_split #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && in_tready),
    .in_pid     (in_tdata[15:0]),
    .in_addr    (in_tdata[47:16]),
    .out_valid  (sp_valid),
    .out_pid    (sp_pid),
    .out_page   (sp_page),
    .out_offset (sp_ofs)
  );

  always_comb begin
    chain[0].valid = sp_valid;
    chain[0].hit   = 1'b0;
    chain[0].pid   = sp_pid;
    chain[0].page  = sp_page;
    chain[0].frame = sp_page;
  end

  for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
    tlbf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (active[g]),
      .wr_en   (wr_en[g]),
      .wr_data (wr_data),
      .q_in    (chain[g]),
      .q_out   (chain[g+1])
    );
  end

  assign exit_q = chain[TLB_DEPTH];
  assign ins_en = exit_q.valid && !exit_q.hit;

  always_comb begin
    wr_data.pid   = exit_q.pid;
    wr_data.page  = exit_q.page;
    wr_data.frame = exit_q.page;
  end

  // fill free slots first, then replace oldest in FIFO order
  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    old_slot = (NW'(ptr_r) >= n_act) ? '0 : ptr_r;
    if (fill_r < n_act) begin
      ins_slot = fill_r[PW-1:0];
      if (ins_en) begin
        fill_nxt = fill_r + 1'b1;
      end
    end else begin
      ins_slot = old_slot;
      if (ins_en) begin
        ptr_nxt = ((NW'(old_slot) + 1'b1) == n_act) ? '0 : (old_slot + 1'b1);
      end
    end
  end

  assign fprod    = exit_q.frame * PB;
  assign load_out = fin_valid_r && (!out_valid_r || out_tready);
  assign phys     = fprod_r + PADDR_W'(ofs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      busy_r      <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
      end else if (load_out) begin
        busy_r <= 1'b0;
      end
      if (exit_q.valid) begin
        fin_valid_r <= 1'b1;
      end else if (load_out) begin
        fin_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sp_valid) begin
      ofs_r <= sp_ofs;
    end
    if (exit_q.valid) begin
      fprod_r    <= fprod[PADDR_W-1:0];
      fin_hit_r  <= exit_q.hit;
      fin_page_r <= exit_q.page;
    end
    if (load_out) begin
      out_data_r <= {5'd0, fin_page_r, phys};
      out_hit_r  <= fin_hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  `TLBF_ASSERT_NXT(a_accept_blocks, clk, rst_n, in_tvalid && in_tready, !in_tready,
                   "beat accepted while lookup in flight")
  `TLBF_ASSERT_IMP(a_exit_busy, clk, rst_n, exit_q.valid, busy_r && !fin_valid_r,
                   "chain exit without pending lookup")
  `TLBF_ASSERT_NXT(a_fill_step, clk, rst_n, ins_en && (fill_r < n_act),
                   fill_r == ($past(fill_r) + 1'b1), "fill count did not advance on miss")

endmodule
